FILE: design/stack_with_middle_and_half_reverse_top_defines.svh
// Assertion macros shared by the stack design.
`ifndef STACK_WITH_MIDDLE_AND_HALF_REVERSE_TOP_DEFINES_SVH
`define STACK_WITH_MIDDLE_AND_HALF_REVERSE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SMHR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("smhr assertion failed");
`define SMHR_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("smhr forbidden condition seen");
`else
`define SMHR_ASSERT(lbl, clk, rst, prop)
`define SMHR_NEVER(lbl, clk, rst, cond)
`endif

`endif

FILE: design/smhr_pkg.sv
package smhr_pkg;

   localparam int WORD_W  = 32;
   localparam int DEPTH_W = 5;

   typedef enum logic [1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_REV  = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FEW   = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EXEC    = 8'b0000_0010,
      S_SWAP_RA = 8'b0000_0100,
      S_SWAP_RB = 8'b0000_1000,
      S_SWAP_WA = 8'b0001_0000,
      S_SWAP_WB = 8'b0010_0000,
      S_MID_RD  = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

endpackage

FILE: design/smhr_mem.sv
module smhr_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [smhr_pkg::WORD_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [smhr_pkg::WORD_W-1:0] rd_data
);

   logic [smhr_pkg::WORD_W-1:0] mem [DEPTH];
   logic [smhr_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/stack_with_middle_and_half_reverse_top.sv
// Bounded stack of signed 32-bit words, DEPTH entries, with a middle-entry report
// and an in-place reversal of the bottom half.
// Request channel: drive req_mode and req_push_value with start high; the
// transaction is taken on a rising edge where start is high and busy is low.
// busy stays high until the response has been issued.
// Response channel: rsp_strobe is high for exactly one cycle and carries
// rsp_status, rsp_depth_now, rsp_middle_valid and rsp_middle_word. The
// receiver cannot hold it off; it must take the response in that cycle.
// Push, pop, idle code and refused operations pass through S_EXEC, S_MID_RD
// and S_RESP after acceptance, and a new request is taken once busy is low
// again. A reversal adds S_SWAP_RA, S_SWAP_RB, S_SWAP_WA and S_SWAP_WB per
// swapped pair, floor(count/4) pairs, since each swap runs two reads and two
// writes in turn through the entry memory's one read and one write port.
// Reset empties the stack (count to zero) and returns to idle; the memory is
// not cleared, as an entry at or above the count never reaches rsp_middle_word.
`include "stack_with_middle_and_half_reverse_top_defines.svh"

module stack_with_middle_and_half_reverse_top #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_mode,
   input  logic signed [smhr_pkg::WORD_W-1:0] req_push_value,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [smhr_pkg::DEPTH_W-1:0]       rsp_depth_now,
   output logic                               rsp_middle_valid,
   output logic signed [smhr_pkg::WORD_W-1:0] rsp_middle_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   smhr_pkg::state_type  state_ff, state_in;
   smhr_pkg::status_type status_ff, status_in;
   smhr_pkg::mode_type   mode_ff, mode_in;
   logic [smhr_pkg::WORD_W-1:0] value_ff, value_in;
   logic [smhr_pkg::WORD_W-1:0] tmp_ff, tmp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;

   logic [AW-1:0] half;
   logic [AW-1:0] pairs;
   logic [AW-1:0] lo_addr;
   logic [AW-1:0] hi_addr;
   logic [AW-1:0] mid_addr;
   logic [CW-1:0] count_m1;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [smhr_pkg::WORD_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [smhr_pkg::WORD_W-1:0] rd_data;

   assign half     = AW'(count_ff >> 1);
   assign pairs    = AW'(count_ff >> 2);
   assign lo_addr  = idx_ff;
   assign hi_addr  = half - AW'(1) - idx_ff;
   assign count_m1 = count_ff - CW'(1);
   assign mid_addr = AW'(count_m1 >> 1);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      mode_in   = mode_ff;
      value_in  = value_ff;
      tmp_in    = tmp_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = lo_addr;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = lo_addr;
      unique case (state_ff)
         smhr_pkg::S_IDLE: begin
            if (start) begin
               mode_in  = smhr_pkg::mode_type'(req_mode);
               value_in = req_push_value;
               state_in = smhr_pkg::S_EXEC;
            end
         end
         smhr_pkg::S_EXEC: begin
            status_in = smhr_pkg::ST_OK;
            idx_in    = '0;
            state_in  = smhr_pkg::S_MID_RD;
            unique case (mode_ff)
               smhr_pkg::MODE_PUSH: begin
                  if (count_ff >= FULL_COUNT) begin
                     status_in = smhr_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(count_ff);
                     wr_data  = value_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               smhr_pkg::MODE_POP: begin
                  if (count_ff == '0) begin
                     status_in = smhr_pkg::ST_EMPTY;
                  end else begin
                     count_in = count_m1;
                  end
               end
               smhr_pkg::MODE_REV: begin
                  if (count_ff < CW'(2)) begin
                     status_in = smhr_pkg::ST_FEW;
                  end else if (pairs != '0) begin
                     state_in = smhr_pkg::S_SWAP_RA;
                  end
               end
               default: begin
               end
            endcase
         end
         smhr_pkg::S_SWAP_RA: begin
            rd_en    = 1'b1;
            rd_addr  = lo_addr;
            state_in = smhr_pkg::S_SWAP_RB;
         end
         smhr_pkg::S_SWAP_RB: begin
            // low entry arrives now; park it while the high entry is fetched
            rd_en    = 1'b1;
            rd_addr  = hi_addr;
            tmp_in   = rd_data;
            state_in = smhr_pkg::S_SWAP_WA;
         end
         smhr_pkg::S_SWAP_WA: begin
            wr_en    = 1'b1;
            wr_addr  = lo_addr;
            wr_data  = rd_data;
            state_in = smhr_pkg::S_SWAP_WB;
         end
         smhr_pkg::S_SWAP_WB: begin
            wr_en   = 1'b1;
            wr_addr = hi_addr;
            wr_data = tmp_ff;
            idx_in  = idx_ff + AW'(1);
            if (idx_ff + AW'(1) == pairs) begin
               state_in = smhr_pkg::S_MID_RD;
            end else begin
               state_in = smhr_pkg::S_SWAP_RA;
            end
         end
         smhr_pkg::S_MID_RD: begin
            rd_en    = 1'b1;
            rd_addr  = mid_addr;
            state_in = smhr_pkg::S_RESP;
         end
         smhr_pkg::S_RESP: begin
            state_in = smhr_pkg::S_IDLE;
         end
         default: begin
            state_in = smhr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smhr_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      mode_ff   <= mode_in;
      value_ff  <= value_in;
      tmp_ff    <= tmp_in;
      idx_ff    <= idx_in;
   end

   smhr_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy             = (state_ff != smhr_pkg::S_IDLE);
   assign rsp_strobe       = (state_ff == smhr_pkg::S_RESP);
   assign rsp_status       = status_ff;
   assign rsp_depth_now    = smhr_pkg::DEPTH_W'(count_ff);
   assign rsp_middle_valid = (count_ff != '0);
   assign rsp_middle_word  = rsp_middle_valid ? signed'(rd_data) : '0;

   `SMHR_NEVER(a_count_bound, clock, reset, count_ff > FULL_COUNT)
   `SMHR_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `SMHR_ASSERT(a_resp_free, clock, reset, rsp_strobe |=> !busy)
   `SMHR_ASSERT(a_full_count, clock, reset,
      (rsp_strobe && rsp_status == smhr_pkg::ST_FULL) |-> (count_ff == FULL_COUNT))
   `SMHR_ASSERT(a_swap_order, clock, reset,
      (state_ff == smhr_pkg::S_SWAP_RA) |-> (lo_addr < hi_addr))

endmodule

FILE: tb/testbench.sv
module testbench;

   localparam int STACK_DEPTH = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_OPS  = 680;
   localparam int DRAIN_WAIT  = 2 * STACK_DEPTH;

   typedef struct packed {
      smhr_pkg::status_type                 status;
      logic [smhr_pkg::DEPTH_W-1:0]         depth;
      logic                                 valid;
      logic signed [smhr_pkg::WORD_W-1:0]   word;
   } stack_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic [1:0]                           req_mode = smhr_pkg::MODE_NOP;
   logic signed [smhr_pkg::WORD_W-1:0]   req_push_value = '0;
   logic                                 busy;
   logic                                 rsp_strobe;
   logic [1:0]                           rsp_status;
   logic [smhr_pkg::DEPTH_W-1:0]         rsp_depth_now;
   logic                                 rsp_middle_valid;
   logic signed [smhr_pkg::WORD_W-1:0]   rsp_middle_word;

   // shadow copy of the stack contents and fill level
   logic signed [smhr_pkg::WORD_W-1:0]   shadow_entries [STACK_DEPTH];
   int unsigned                          shadow_count = 0;

   stack_result_type            pending_results [$];
   stack_result_type            oldest_result;
   int                          mismatch_count = 0;
   int                          stall_cycles = 0;
   bit                          gaps_on = 1'b1;

   stack_with_middle_and_half_reverse_top #(
      .DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_push_value   (req_push_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_depth_now    (rsp_depth_now),
      .rsp_middle_valid (rsp_middle_valid),
      .rsp_middle_word  (rsp_middle_word)
   );

   always #2 clock = ~clock;

   function automatic stack_result_type predict_stack_op(
      input smhr_pkg::mode_type op,
      input logic signed [smhr_pkg::WORD_W-1:0] value);
      stack_result_type                     res;
      int unsigned                          half;
      logic signed [smhr_pkg::WORD_W-1:0]   tmp;
      res.status = smhr_pkg::ST_OK;
      case (op)
         smhr_pkg::MODE_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               res.status = smhr_pkg::ST_FULL;
            end else begin
               shadow_entries[shadow_count] = value;
               shadow_count++;
            end
         end
         smhr_pkg::MODE_POP: begin
            if (shadow_count == 0) res.status = smhr_pkg::ST_EMPTY;
            else shadow_count--;
         end
         smhr_pkg::MODE_REV: begin
            if (shadow_count < 2) begin
               res.status = smhr_pkg::ST_FEW;
            end else begin
               // mirror the bottom half of the entries in place
               half = shadow_count / 2;
               for (int unsigned i = 0; i < half / 2; i++) begin
                  tmp = shadow_entries[i];
                  shadow_entries[i] = shadow_entries[half - 1 - i];
                  shadow_entries[half - 1 - i] = tmp;
               end
            end
         end
         default: ;
      endcase
      res.depth = shadow_count[smhr_pkg::DEPTH_W-1:0];
      res.valid = (shadow_count > 0);
      res.word  = res.valid ? shadow_entries[(shadow_count - 1) / 2] : '0;
      return res;
   endfunction

   task automatic issue_op(input smhr_pkg::mode_type op,
                           input logic signed [smhr_pkg::WORD_W-1:0] value);
      @(negedge clock);
      // let the transaction in flight finish so that gaps fall on an idle block
      while (busy) @(negedge clock);
      while (gaps_on && $urandom_range(99) < 8) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_mode       <= op;
      req_push_value <= value;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_stack_op(op, value));
   endtask

   function automatic logic signed [smhr_pkg::WORD_W-1:0] pick_word();
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic test_edge_cases();
      issue_op(smhr_pkg::MODE_POP, 32'sh1234_5678);
      issue_op(smhr_pkg::MODE_REV, '0);
      issue_op(smhr_pkg::MODE_NOP, -32'sd1);
      issue_op(smhr_pkg::MODE_PUSH, 32'sh8000_0000);
      issue_op(smhr_pkg::MODE_REV, '0);
      issue_op(smhr_pkg::MODE_PUSH, 32'sh7FFF_FFFF);
      issue_op(smhr_pkg::MODE_REV, '0);
      issue_op(smhr_pkg::MODE_NOP, '0);
      issue_op(smhr_pkg::MODE_POP, '0);
      issue_op(smhr_pkg::MODE_POP, '0);
   endtask

   task automatic test_full_stack();
      for (int i = 0; i < STACK_DEPTH; i++) issue_op(smhr_pkg::MODE_PUSH, pick_word());
      issue_op(smhr_pkg::MODE_PUSH, -32'sd1);
      issue_op(smhr_pkg::MODE_REV, '0);
      issue_op(smhr_pkg::MODE_POP, '0);
   endtask

   task automatic test_random_ops();
      bit                 filling = 1'b1;
      int                 roll;
      smhr_pkg::mode_type op;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         // hold off idle gaps through a long stretch in the middle
         gaps_on = !(n >= 200 && n < 400);
         if (shadow_count >= STACK_DEPTH && $urandom_range(9) < 3) filling = 1'b0;
         if (shadow_count == 0 && $urandom_range(9) < 3) filling = 1'b1;
         if ($urandom_range(99) < 3) filling = !filling;
         roll = $urandom_range(99);
         if (roll < 50) op = filling ? smhr_pkg::MODE_PUSH : smhr_pkg::MODE_POP;
         else if (roll < 65) op = filling ? smhr_pkg::MODE_POP : smhr_pkg::MODE_PUSH;
         else if (roll < 93) op = smhr_pkg::MODE_REV;
         else op = smhr_pkg::MODE_NOP;
         issue_op(op, pick_word());
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing outstanding");
               mismatch_count++;
            end else begin
               oldest_result = pending_results.pop_front();
               if (rsp_status !== oldest_result.status) begin
                  $error("status: expected %0d, got %0d", oldest_result.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_depth_now !== oldest_result.depth) begin
                  $error("depth_now: expected %0d, got %0d", oldest_result.depth,
                         rsp_depth_now);
                  mismatch_count++;
               end
               if (rsp_middle_valid !== oldest_result.valid) begin
                  $error("middle_valid: expected %0d, got %0d", oldest_result.valid,
                         rsp_middle_valid);
                  mismatch_count++;
               end
               if (rsp_middle_word !== oldest_result.word) begin
                  $error("middle_word: expected %0d, got %0d", oldest_result.word,
                         rsp_middle_word);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_full_stack();
      test_random_ops();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: stack_with_middle_and_half_reverse_top.f
+incdir+design
design/smhr_pkg.sv
design/smhr_mem.sv
design/stack_with_middle_and_half_reverse_top.sv
tb/testbench.sv
